### rtl/mts_pkg.sv
// Package with the shared constants, types and state codes of the min-tracking stack.
package mts_pkg;

   localparam int DEPTH       = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int ENTRY_WIDTH = DATA_WIDTH + 2;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam int ADDR_WIDTH  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Operation codes of the kind field.
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef logic signed [DATA_WIDTH-1:0]  data_type;
   typedef logic signed [ENTRY_WIDTH-1:0] entry_type;
   typedef logic [COUNT_WIDTH-1:0]        count_type;
   typedef logic [ADDR_WIDTH-1:0]         addr_type;

   typedef struct packed {
      logic     kind;
      data_type data_value;
   } req_type;

   typedef struct packed {
      data_type  popped_value;
      data_type  top_value;
      data_type  min_value;
      count_type entry_count;
      logic      underflow;
      logic      overflow;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic execute;
      logic complete;
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_FINISH
   } state_type;

endpackage

### rtl/mts_ctrl.sv
// Controller state machine that sequences the accept and finish states of one stack item.
module mts_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output mts_pkg::cmd_type cmd
);

   mts_pkg::state_type state_ff;
   mts_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands. The operation runs at the accepting edge; the
   // following cycle waits for the memory read and builds the result.
   always_comb begin
      state_in     = state_ff;
      busy         = 1'b0;
      cmd.execute  = 1'b0;
      cmd.complete = 1'b0;
      case (state_ff)
         mts_pkg::ST_IDLE: begin
            if (start) begin
               cmd.execute = 1'b1;
               state_in    = mts_pkg::ST_FINISH;
            end
         end
         mts_pkg::ST_FINISH: begin
            busy         = 1'b1;
            cmd.complete = 1'b1;
            state_in     = mts_pkg::ST_IDLE;
         end
         default: begin
            state_in = mts_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/mts_datapath.sv
// Datapath with the entry memory, stack pointer, running minimum and result register.
module mts_datapath (
   input  logic             clock,
   input  logic             reset,
   input  mts_pkg::cmd_type cmd,
   input  mts_pkg::req_type req_data,
   output logic             rsp_strobe,
   output mts_pkg::rsp_type rsp_data
);

   // Entry memory with a registered read port.
   mts_pkg::entry_type mem [mts_pkg::DEPTH];
   mts_pkg::entry_type rd_data_ff;

   mts_pkg::count_type sp_ff;
   mts_pkg::count_type sp_in;
   mts_pkg::data_type  min_ff;
   mts_pkg::data_type  min_in;
   mts_pkg::entry_type top_entry_ff;
   mts_pkg::entry_type top_entry_in;
   mts_pkg::data_type  popped_ff;
   mts_pkg::data_type  popped_in;
   logic               pop_read_ff;
   logic               under_ff;
   logic               over_ff;
   logic               rsp_strobe_ff;
   mts_pkg::rsp_type   rsp_data_ff;
   mts_pkg::rsp_type   rsp_data_in;

   logic               is_pop;
   logic               is_empty;
   logic               is_full;
   logic               do_push;
   logic               do_pop;
   mts_pkg::entry_type val_e;
   mts_pkg::entry_type min_e;
   mts_pkg::entry_type push_entry;
   mts_pkg::count_type below_idx;
   mts_pkg::entry_type top_raw;

   assign is_pop   = (req_data.kind == mts_pkg::KIND_POP);
   assign is_empty = (sp_ff == '0);
   assign is_full  = (sp_ff == mts_pkg::count_type'(mts_pkg::DEPTH));
   assign do_push  = cmd.execute && !is_pop && !is_full;
   assign do_pop   = cmd.execute && is_pop && !is_empty;
   assign val_e    = mts_pkg::entry_type'(req_data.data_value);
   assign min_e    = mts_pkg::entry_type'(min_ff);
   assign below_idx = sp_ff - mts_pkg::count_type'(2);

   // Operation at the accepting edge: encode on push, decode on pop.
   always_comb begin
      sp_in        = sp_ff;
      min_in       = min_ff;
      top_entry_in = top_entry_ff;
      popped_in    = '0;
      push_entry   = val_e;
      if (do_push) begin
         sp_in = sp_ff + mts_pkg::count_type'(1);
         if (is_empty) begin
            min_in = req_data.data_value;
         end else if (val_e < min_e) begin
            push_entry = val_e + val_e - min_e;
            min_in     = req_data.data_value;
         end
         top_entry_in = push_entry;
      end else if (do_pop) begin
         sp_in = sp_ff - mts_pkg::count_type'(1);
         if (top_entry_ff >= min_e) begin
            popped_in = mts_pkg::data_type'(top_entry_ff);
         end else begin
            popped_in = min_ff;
            min_in    = mts_pkg::data_type'(min_e + min_e - top_entry_ff);
         end
      end
   end

   // Memory write on push and an unconditional read of the entry below the top, used on pop.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[sp_ff[mts_pkg::ADDR_WIDTH-1:0]] <= push_entry;
      end
      rd_data_ff <= mem[below_idx[mts_pkg::ADDR_WIDTH-1:0]];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff         <= '0;
         min_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         sp_ff         <= sp_in;
         min_ff        <= min_in;
         rsp_strobe_ff <= cmd.complete;
      end
   end

   // Per-item payload registers.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         popped_ff   <= popped_in;
         pop_read_ff <= do_pop;
         under_ff    <= is_pop && is_empty;
         over_ff     <= !is_pop && is_full;
      end
      if (cmd.complete && pop_read_ff) begin
         top_entry_ff <= rd_data_ff;
      end else begin
         top_entry_ff <= top_entry_in;
      end
      if (cmd.complete) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Result built from the state left by the operation.
   assign top_raw = pop_read_ff ? rd_data_ff : top_entry_ff;

   always_comb begin
      rsp_data_in.popped_value = popped_ff;
      rsp_data_in.top_value    = '0;
      rsp_data_in.min_value    = '0;
      rsp_data_in.entry_count  = sp_ff;
      rsp_data_in.underflow    = under_ff;
      rsp_data_in.overflow     = over_ff;
      if (sp_ff != '0) begin
         rsp_data_in.min_value = min_ff;
         if (top_raw >= min_e) begin
            rsp_data_in.top_value = mts_pkg::data_type'(top_raw);
         end else begin
            rsp_data_in.top_value = min_ff;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

### rtl/min_tracking_stack_top.sv
// Top level of the min-tracking stack: LIFO whose running minimum sits in one register.
// Every item passes an accept and a finish state: busy is high for one cycle after start is taken,
// while the entry memory delivers the entry below the top.
// The result strobe is registered after the finish state; start is not taken while busy is high.
// The next item may be taken in the same cycle as the result strobe.
// Synchronous reset empties the stack and clears the minimum; memory is not cleared.
module min_tracking_stack_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mts_pkg::req_type req_data,
   output logic             rsp_strobe,
   output mts_pkg::rsp_type rsp_data
);

   mts_pkg::cmd_type cmd;

   // Sequencing.
   mts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Storage and arithmetic.
   mts_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
